@@ sv/linear_residual_deadzone_rms_core_macros.svh @@
// ----------------------------------------------------------------------------
// linear_residual_deadzone_rms_core assertion macros
// shared property wrappers, clocked on aclk and disabled while aresetn is low
// ----------------------------------------------------------------------------
`ifndef LINEAR_RESIDUAL_DEADZONE_RMS_CORE_MACROS_SVH
`define LINEAR_RESIDUAL_DEADZONE_RMS_CORE_MACROS_SVH

// same-cycle implication
`define LRDR_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LRDR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/lrdr_pkg.sv @@
// ----------------------------------------------------------------------------
// lrdr_pkg
// widths, codes and interface types of the residual dead-zone rms core
// ----------------------------------------------------------------------------
package lrdr_pkg;

    localparam int DATA_W          = 16;
    localparam int TOL_W           = 15;
    localparam int NUM_PRED        = 5;
    localparam int PROD_W          = 2 * DATA_W;
    localparam int ACC_W           = 35;
    localparam int FRAC_SHIFT      = 12;
    localparam int SUM_W           = 48;
    localparam int ROOT_W          = SUM_W / 2;
    localparam int MAX_SAMPLES_DEF = 1024;
    localparam int CFG_IDX_W       = 3;
    localparam int S_TDATA_W       = (NUM_PRED + 1) * DATA_W;
    localparam int M_TDATA_W       = 2 * DATA_W;

    localparam logic [TOL_W-1:0] TOL_RESET = 15'd142;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BIAS         = 3'd0,
        CFG_WEIGHT_ONE   = 3'd1,
        CFG_WEIGHT_TWO   = 3'd2,
        CFG_WEIGHT_THREE = 3'd3,
        CFG_WEIGHT_FOUR  = 3'd4,
        CFG_WEIGHT_FIVE  = 3'd5,
        CFG_TOLERANCE    = 3'd6
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MAC,
        ST_MAC_END,
        ST_ROUND,
        ST_SQUARE,
        ST_ACCUM,
        ST_DS_START,
        ST_DS_WAIT,
        ST_OUT
    } core_state_t;

    typedef enum logic [1:0] {
        DS_IDLE,
        DS_DIV,
        DS_SQRT,
        DS_DONE
    } ds_state_t;

    typedef struct packed {
        logic start;
    } ds_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } ds_stat_t;

endpackage

@@ sv/lrdr_divsqrt.sv @@
// ----------------------------------------------------------------------------
// lrdr_divsqrt
// mean and root of the run: restoring divide then digit-by-digit square root,
// both sharing one compare-and-subtract unit, one bit of result per cycle
// ----------------------------------------------------------------------------
`include "linear_residual_deadzone_rms_core_macros.svh"

module lrdr_divsqrt #(
    parameter int DIV_W = 11
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  lrdr_pkg::ds_ctrl_t           ctrl,
    input  logic [lrdr_pkg::SUM_W-1:0]   dividend,
    input  logic [DIV_W-1:0]             divisor,
    output lrdr_pkg::ds_stat_t           stat,
    output logic [lrdr_pkg::DATA_W-1:0]  root
);

    localparam int SUM_W  = lrdr_pkg::SUM_W;
    localparam int ROOT_W = lrdr_pkg::ROOT_W;
    localparam int DATA_W = lrdr_pkg::DATA_W;
    localparam int SUB_W  = (DIV_W + 1 > ROOT_W + 3) ? DIV_W + 1 : ROOT_W + 3;
    localparam int STEP_W = $clog2(SUM_W);

    lrdr_pkg::ds_state_t state_reg, state_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [SUB_W-1:0]    rem_reg, rem_next;
    logic [SUM_W-1:0]    work_reg, work_next;
    logic [ROOT_W-1:0]   root_reg, root_next;
    logic [DIV_W-1:0]    div_reg, div_next;

    // shared subtractor
    logic [SUB_W-1:0] sub_a, sub_b;
    logic [SUB_W:0]   diff;
    logic             ge;

    always_comb begin
        if (state_reg == lrdr_pkg::DS_SQRT) begin
            sub_a = {rem_reg[SUB_W-3:0], work_reg[SUM_W-1 -: 2]};
            sub_b = SUB_W'({root_reg, 2'b01});
        end else begin
            sub_a = {rem_reg[SUB_W-2:0], work_reg[SUM_W-1]};
            sub_b = SUB_W'(div_reg);
        end
        diff = {1'b0, sub_a} - {1'b0, sub_b};
        ge   = !diff[SUB_W];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lrdr_pkg::DS_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
        rem_reg  <= rem_next;
        work_reg <= work_next;
        root_reg <= root_next;
        div_reg  <= div_next;
    end

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        rem_next   = rem_reg;
        work_next  = work_reg;
        root_next  = root_reg;
        div_next   = div_reg;
        stat.done  = 1'b0;
        stat.busy  = (state_reg != lrdr_pkg::DS_IDLE);
        unique case (state_reg)
            lrdr_pkg::DS_IDLE: begin
                if (ctrl.start) begin
                    div_next   = divisor;
                    work_next  = dividend;
                    rem_next   = '0;
                    step_next  = '0;
                    state_next = lrdr_pkg::DS_DIV;
                end
            end
            lrdr_pkg::DS_DIV: begin
                rem_next  = ge ? diff[SUB_W-1:0] : sub_a;
                work_next = {work_reg[SUM_W-2:0], ge};
                if (step_reg == STEP_W'(SUM_W - 1)) begin
                    // quotient now sits in work_reg, root starts from zero
                    rem_next   = '0;
                    root_next  = '0;
                    step_next  = '0;
                    state_next = lrdr_pkg::DS_SQRT;
                end else begin
                    step_next = step_reg + 1'b1;
                end
            end
            lrdr_pkg::DS_SQRT: begin
                rem_next  = ge ? diff[SUB_W-1:0] : sub_a;
                root_next = {root_reg[ROOT_W-2:0], ge};
                work_next = {work_reg[SUM_W-3:0], 2'b00};
                if (step_reg == STEP_W'(ROOT_W - 1)) begin
                    state_next = lrdr_pkg::DS_DONE;
                end else begin
                    step_next = step_reg + 1'b1;
                end
            end
            lrdr_pkg::DS_DONE: begin
                stat.done  = 1'b1;
                state_next = lrdr_pkg::DS_IDLE;
            end
            default: begin
                state_next = lrdr_pkg::DS_IDLE;
            end
        endcase
    end

    // score saturates at the top of the q8.8 range
    assign root = (|root_reg[ROOT_W-1:DATA_W]) ? {DATA_W{1'b1}} : root_reg[DATA_W-1:0];

    `LRDR_ASSERT_IMPL(a_start_idle, ctrl.start, state_reg == lrdr_pkg::DS_IDLE, "start while busy")
    `LRDR_ASSERT_IMPL(a_rem_below_div, state_reg == lrdr_pkg::DS_DIV,
        rem_reg < SUB_W'(div_reg), "divide remainder not below divisor")
    `LRDR_ASSERT_NEXT(a_div_to_sqrt,
        state_reg == lrdr_pkg::DS_DIV && step_reg == STEP_W'(SUM_W - 1),
        state_reg == lrdr_pkg::DS_SQRT && rem_reg == '0 && root_reg == '0,
        "root phase did not start clean")

endmodule

@@ sv/linear_residual_deadzone_rms_core.sv @@
// ----------------------------------------------------------------------------
// linear_residual_deadzone_rms_core
// linear residual with dead-zone penalty and per-run root mean square score
// ----------------------------------------------------------------------------
//  channel  | direction | handshake            | payload
//  s_       | in        | s_tvalid / s_tready  | s_tdata predictors + error, s_tlast
//  m_       | out       | m_tvalid / m_tready  | m_tdata residual + score, m_tuser
//  cfg_     | in        | cfg_valid / cfg_ready| cfg_index, cfg_data
//
//  one 16x16 multiplier serves the five weight products and the square, so an
//  ordinary sample passes five multiply steps, a closing add, the rounding, the
//  square, the accumulate and the output step before the core is ready again
//  a last sample adds a start state, then a 48-step divide, a 24-step root and a
//  done state in lrdr_divsqrt, which share one subtractor
//  s_tready is high only while idle; a result waits in the output register and
//  stalls the core only if the next result is finished before it is taken
//  reset is synchronous, active low, and clears the run sum and count
// ----------------------------------------------------------------------------
`include "linear_residual_deadzone_rms_core_macros.svh"

module linear_residual_deadzone_rms_core #(
    parameter int MAX_SAMPLES = lrdr_pkg::MAX_SAMPLES_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // pred_one, pred_two, pred_three, pred_four, pred_five, model_error
    input  logic [lrdr_pkg::S_TDATA_W-1:0]    s_tdata,
    input  logic                              s_tlast,   // last_sample
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // residual, run_score
    output logic [lrdr_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic                              m_tuser,   // score_valid
    output logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [lrdr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lrdr_pkg::DATA_W-1:0]       cfg_data
);

    localparam int DATA_W   = lrdr_pkg::DATA_W;
    localparam int TOL_W    = lrdr_pkg::TOL_W;
    localparam int NUM_PRED = lrdr_pkg::NUM_PRED;
    localparam int PROD_W   = lrdr_pkg::PROD_W;
    localparam int ACC_W    = lrdr_pkg::ACC_W;
    localparam int SHIFT    = lrdr_pkg::FRAC_SHIFT;
    localparam int SUM_W    = lrdr_pkg::SUM_W;
    localparam int CNT_W    = $clog2(MAX_SAMPLES + 1);
    localparam int IDX_W    = $clog2(NUM_PRED);
    localparam int RW_W     = ACC_W - SHIFT;

    // configuration registers
    logic signed [DATA_W-1:0] bias_reg;
    logic signed [DATA_W-1:0] weight_reg [NUM_PRED];
    logic [TOL_W-1:0]         tol_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bias_reg <= '0;
            for (int i = 0; i < NUM_PRED; i++) begin
                weight_reg[i] <= '0;
            end
            tol_reg <= lrdr_pkg::TOL_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (lrdr_pkg::cfg_idx_t'(cfg_index))
                lrdr_pkg::CFG_BIAS:         bias_reg      <= cfg_data;
                lrdr_pkg::CFG_WEIGHT_ONE:   weight_reg[0] <= cfg_data;
                lrdr_pkg::CFG_WEIGHT_TWO:   weight_reg[1] <= cfg_data;
                lrdr_pkg::CFG_WEIGHT_THREE: weight_reg[2] <= cfg_data;
                lrdr_pkg::CFG_WEIGHT_FOUR:  weight_reg[3] <= cfg_data;
                lrdr_pkg::CFG_WEIGHT_FIVE:  weight_reg[4] <= cfg_data;
                lrdr_pkg::CFG_TOLERANCE:    tol_reg       <= cfg_data[TOL_W-1:0];
                default: ;
            endcase
        end
    end

    // sequencer and datapath registers
    lrdr_pkg::core_state_t state_reg, state_next;
    logic [IDX_W-1:0]         mac_idx_reg, mac_idx_next;
    logic signed [DATA_W-1:0] pred_reg [NUM_PRED];
    logic signed [DATA_W-1:0] pred_next [NUM_PRED];
    logic                     last_reg, last_next;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic signed [DATA_W-1:0] r_reg, r_next;
    logic                     pen_reg, pen_next;
    logic [SUM_W-1:0]         sum_reg, sum_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic [DATA_W-1:0]        score_reg, score_next;
    logic                     m_tvalid_reg, m_tvalid_next;
    logic [lrdr_pkg::M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic                     m_tuser_reg, m_tuser_next;

    lrdr_pkg::ds_ctrl_t       ds_ctrl;
    lrdr_pkg::ds_stat_t       ds_stat;
    logic [DATA_W-1:0]        ds_root;

    // shared multiplier
    logic signed [DATA_W-1:0] mul_a, mul_b;
    logic signed [PROD_W-1:0] prod_full;

    assign mul_a     = (state_reg == lrdr_pkg::ST_SQUARE) ? r_reg : weight_reg[mac_idx_reg];
    assign mul_b     = (state_reg == lrdr_pkg::ST_SQUARE) ? r_reg : pred_reg[mac_idx_reg];
    assign prod_full = mul_a * mul_b;

    logic signed [ACC_W-1:0]  prod_ext;
    logic signed [DATA_W:0]   offset_sum;
    logic signed [ACC_W-1:0]  acc_init;
    logic signed [ACC_W-1:0]  acc_rnd;
    logic signed [RW_W-1:0]   r_wide;
    logic [RW_W-DATA_W:0]     r_hi;
    logic signed [DATA_W-1:0] r_sat;
    logic [DATA_W:0]          r_mag;
    logic [SUM_W:0]           sum_add;

    always_comb begin
        prod_ext   = {{(ACC_W - PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
        offset_sum = {s_tdata[NUM_PRED*DATA_W + DATA_W - 1], s_tdata[NUM_PRED*DATA_W +: DATA_W]}
                   + {bias_reg[DATA_W-1], bias_reg};
        acc_init   = {{(ACC_W - DATA_W - 1 - SHIFT){offset_sum[DATA_W]}}, offset_sum,
                      {SHIFT{1'b0}}};
        // round half up, then floor shift
        acc_rnd    = acc_reg + ACC_W'(1 << (SHIFT - 1));
        r_wide     = acc_rnd[ACC_W-1:SHIFT];
        r_hi       = r_wide[RW_W-1:DATA_W-1];
        if (!r_wide[RW_W-1] && (|r_hi)) begin
            r_sat = {1'b0, {(DATA_W-1){1'b1}}};
        end else if (r_wide[RW_W-1] && !(&r_hi)) begin
            r_sat = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            r_sat = r_wide[DATA_W-1:0];
        end
        r_mag   = r_reg[DATA_W-1] ? ((DATA_W+1)'(0) - {r_reg[DATA_W-1], r_reg})
                                  : {1'b0, r_reg};
        sum_add = {1'b0, sum_reg} + (SUM_W+1)'(prod_reg[PROD_W-2:0]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= lrdr_pkg::ST_IDLE;
            sum_reg      <= '0;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            sum_reg      <= sum_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        mac_idx_reg <= mac_idx_next;
        for (int i = 0; i < NUM_PRED; i++) begin
            pred_reg[i] <= pred_next[i];
        end
        last_reg    <= last_next;
        acc_reg     <= acc_next;
        prod_reg    <= prod_next;
        r_reg       <= r_next;
        pen_reg     <= pen_next;
        score_reg   <= score_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    always_comb begin
        state_next    = state_reg;
        mac_idx_next  = mac_idx_reg;
        for (int i = 0; i < NUM_PRED; i++) begin
            pred_next[i] = pred_reg[i];
        end
        last_next     = last_reg;
        acc_next      = acc_reg;
        prod_next     = prod_reg;
        r_next        = r_reg;
        pen_next      = pen_reg;
        sum_next      = sum_reg;
        count_next    = count_reg;
        score_next    = score_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        ds_ctrl.start = 1'b0;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            lrdr_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    for (int i = 0; i < NUM_PRED; i++) begin
                        pred_next[i] = s_tdata[i*DATA_W +: DATA_W];
                    end
                    last_next    = s_tlast;
                    acc_next     = acc_init;
                    mac_idx_next = '0;
                    state_next   = lrdr_pkg::ST_MAC;
                end
            end
            lrdr_pkg::ST_MAC: begin
                // product of this step lands in prod_reg, previous one is summed
                prod_next = prod_full;
                if (mac_idx_reg != '0) begin
                    acc_next = acc_reg + prod_ext;
                end
                if (mac_idx_reg == IDX_W'(NUM_PRED - 1)) begin
                    state_next = lrdr_pkg::ST_MAC_END;
                end else begin
                    mac_idx_next = mac_idx_reg + 1'b1;
                end
            end
            lrdr_pkg::ST_MAC_END: begin
                acc_next   = acc_reg + prod_ext;
                state_next = lrdr_pkg::ST_ROUND;
            end
            lrdr_pkg::ST_ROUND: begin
                r_next     = r_sat;
                state_next = lrdr_pkg::ST_SQUARE;
            end
            lrdr_pkg::ST_SQUARE: begin
                prod_next  = prod_full;
                pen_next   = r_mag > (DATA_W+1)'(tol_reg);
                state_next = lrdr_pkg::ST_ACCUM;
            end
            lrdr_pkg::ST_ACCUM: begin
                if (pen_reg) begin
                    sum_next = sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
                end
                if (count_reg < CNT_W'(MAX_SAMPLES)) begin
                    count_next = count_reg + 1'b1;
                end
                score_next = '0;
                state_next = last_reg ? lrdr_pkg::ST_DS_START : lrdr_pkg::ST_OUT;
            end
            lrdr_pkg::ST_DS_START: begin
                ds_ctrl.start = 1'b1;
                state_next    = lrdr_pkg::ST_DS_WAIT;
            end
            lrdr_pkg::ST_DS_WAIT: begin
                if (ds_stat.done) begin
                    score_next = (count_reg == '0) ? '0 : ds_root;
                    sum_next   = '0;
                    count_next = '0;
                    state_next = lrdr_pkg::ST_OUT;
                end
            end
            lrdr_pkg::ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {score_reg, r_reg};
                    m_tuser_next  = last_reg;
                    state_next    = lrdr_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = lrdr_pkg::ST_IDLE;
            end
        endcase
    end

    lrdr_divsqrt #(
        .DIV_W (CNT_W)
    ) u_divsqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (ds_ctrl),
        .dividend (sum_reg),
        .divisor  (count_reg),
        .stat     (ds_stat),
        .root     (ds_root)
    );

    assign s_tready = (state_reg == lrdr_pkg::ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    `LRDR_ASSERT_IMPL(a_count_bound, 1'b1, count_reg <= CNT_W'(MAX_SAMPLES),
        "sample count above limit")
    `LRDR_ASSERT_IMPL(a_score_only_last, m_tvalid_reg && !m_tuser_reg,
        m_tdata_reg[2*DATA_W-1:DATA_W] == '0, "score on a sample that is not last")
    `LRDR_ASSERT_IMPL(a_ds_busy_wait, state_reg == lrdr_pkg::ST_DS_WAIT, ds_stat.busy,
        "waiting on an idle root unit")
    `LRDR_ASSERT_NEXT(a_run_cleared, state_reg == lrdr_pkg::ST_DS_WAIT && ds_stat.done,
        sum_reg == '0 && count_reg == '0, "run state not cleared after score")

endmodule
